FILE: rtl/scmp_pkg.sv
// Package for the compare-string sequencer: field codes, stream widths,
// flag bundle and the element-size helper. No dependencies.
`default_nettype none

package scmp_pkg;

	// Stream payload widths padded to whole bytes, and the input bits in use
	localparam int InDataW  = 232;
	localparam int InUsedW  = 229;
	localparam int OutDataW = 168;

	// Item kinds on the input tuser bit
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Repeat prefix codes (the reserved code behaves as no prefix)
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_REPE  = 2'd1;
	localparam logic [1:0] MODE_REPNE = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// Element width codes (the unused code behaves as doubleword)
	localparam logic [1:0] WIDTH_BYTE  = 2'd0;
	localparam logic [1:0] WIDTH_WORD  = 2'd1;
	localparam logic [1:0] WIDTH_DWORD = 2'd2;

	typedef struct packed {
		logic af;
		logic zf;
		logic sf;
		logic of;
		logic cf;
	} flags_t;

	function automatic logic [2:0] bytes_of(input logic [1:0] w);
		logic [2:0] nb;
		case (w)
			WIDTH_BYTE: nb = 3'd1;
			WIDTH_WORD: nb = 3'd2;
			default:    nb = 3'd4;
		endcase
		return nb;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/scmp_alu.sv
// Element compare: subtracts dest from source at the element width and
// forms CF, OF, SF, ZF and AF. Depends on scmp_pkg.
`default_nettype none

module scmp_alu (
	input  wire logic [31:0]   a,
	input  wire logic [31:0]   b,
	input  wire logic [1:0]    width,
	output scmp_pkg::flags_t   flags
);
	import scmp_pkg::*;

	logic [31:0] mask;
	logic [31:0] a_m;
	logic [31:0] b_m;
	logic [31:0] d;
	logic [31:0] ovf_v;
	logic        top_d;
	logic        top_o;

	always_comb begin
		case (width)
			WIDTH_BYTE: mask = 32'h0000_00FF;
			WIDTH_WORD: mask = 32'h0000_FFFF;
			default:    mask = 32'hFFFF_FFFF;
		endcase
		a_m   = a & mask;
		b_m   = b & mask;
		d     = (a_m - b_m) & mask;
		ovf_v = (a_m ^ b_m) & (a_m ^ d);
		case (width)
			WIDTH_BYTE: begin
				top_d = d[7];
				top_o = ovf_v[7];
			end
			WIDTH_WORD: begin
				top_d = d[15];
				top_o = ovf_v[15];
			end
			default: begin
				top_d = d[31];
				top_o = ovf_v[31];
			end
		endcase
		flags.cf = (a_m < b_m);
		flags.of = top_o;
		flags.sf = top_d;
		flags.zf = (d == 32'd0);
		flags.af = a_m[4] ^ b_m[4] ^ d[4];
	end

endmodule

`default_nettype wire

FILE: rtl/string_compare_rep_sequencer.sv
// Compare-string sequencer top level: input register, state update with
// one compare per data request, and a result register. Depends on scmp_pkg.
// A request accepted into the input register has its result registered on m_axis when it
// advances. Throughput: one request per cycle while m_axis is not stalled, set by the
// combinational state update between the input register and the result register.
// Reset (arst_n low): all offsets, count, modes, flags cleared, idle, pipeline empty.
`default_nettype none

module string_compare_rep_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic                           cfg_wdata,      // address_size_16
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// source_offset, dest_offset, repeat_count, repeat_mode, element_width,
	// direction, source_base, dest_base, source_element, dest_element
	input  wire logic [scmp_pkg::InDataW-1:0]   s_axis_tdata,
	input  wire logic                           s_axis_tuser,   // opcode
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// source_address, dest_address, carry_flag, overflow_flag, sign_flag,
	// zero_flag, adjust_flag, final_source_offset, final_dest_offset, count_left
	output logic [scmp_pkg::OutDataW-1:0]       m_axis_tdata,
	output logic                                m_axis_tuser    // done_res
);
	import scmp_pkg::*;

	logic               asz16_q;

	logic               valid_s1;
	logic               op_s1;
	logic [InUsedW-1:0] data_s1;
	logic               advance;

	logic [31:0] src_off_q, dst_off_q, remaining_q, src_seg_q, dst_seg_q;
	logic [1:0]  mode_q, width_q;
	logic        dir_q, active_q;
	flags_t      flags_q;

	logic [31:0] in_src_off, in_dst_off, in_count, in_src_base, in_dst_base;
	logic [31:0] in_src_elem, in_dst_elem;
	logic [1:0]  in_mode, in_width;
	logic        in_dir;

	logic [31:0] nx_src_off, nx_dst_off, nx_remaining, nx_src_seg, nx_dst_seg;
	logic [1:0]  nx_mode, nx_width;
	logic        nx_dir, nx_active, nx_done;
	flags_t      nx_flags;
	flags_t      alu_flags;

	logic [31:0] am;
	logic [31:0] step;
	logic [31:0] rem_dec;
	logic        stop;

	assign in_src_off  = data_s1[31:0];
	assign in_dst_off  = data_s1[63:32];
	assign in_count    = data_s1[95:64];
	assign in_mode     = data_s1[97:96];
	assign in_width    = data_s1[99:98];
	assign in_dir      = data_s1[100];
	assign in_src_base = data_s1[132:101];
	assign in_dst_base = data_s1[164:133];
	assign in_src_elem = data_s1[196:165];
	assign in_dst_elem = data_s1[228:197];

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	scmp_alu u_alu (
		.a     (in_src_elem),
		.b     (in_dst_elem),
		.width (width_q),
		.flags (alu_flags)
	);

	always_comb begin
		am      = asz16_q ? 32'h0000_FFFF : 32'hFFFF_FFFF;
		step    = dir_q ? (32'd0 - {29'd0, bytes_of(width_q)}) : {29'd0, bytes_of(width_q)};
		rem_dec = (remaining_q - 32'd1) & am;

		nx_src_off   = src_off_q;
		nx_dst_off   = dst_off_q;
		nx_remaining = remaining_q;
		nx_src_seg   = src_seg_q;
		nx_dst_seg   = dst_seg_q;
		nx_mode      = mode_q;
		nx_width     = width_q;
		nx_dir       = dir_q;
		nx_active    = active_q;
		nx_flags     = flags_q;
		nx_done      = 1'b1;
		stop         = 1'b1;

		if (op_s1 == OP_START) begin
			nx_src_off = in_src_off & am;
			nx_dst_off = in_dst_off & am;
			// unknown prefix code behaves as no prefix
			nx_mode    = (in_mode == MODE_RSVD) ? MODE_NONE : in_mode;
			nx_width   = in_width;
			nx_dir     = in_dir;
			nx_src_seg = in_src_base;
			nx_dst_seg = in_dst_base;
			nx_remaining = (nx_mode == MODE_NONE) ? 32'd1 : (in_count & am);
			nx_active  = (nx_remaining != 32'd0);
			nx_done    = !nx_active;
		end else if (active_q) begin
			nx_flags     = alu_flags;
			nx_src_off   = (src_off_q + step) & am;
			nx_dst_off   = (dst_off_q + step) & am;
			nx_remaining = rem_dec;
			case (mode_q)
				MODE_REPE:  stop = (rem_dec == 32'd0) || !alu_flags.zf;
				MODE_REPNE: stop = (rem_dec == 32'd0) || alu_flags.zf;
				default:    stop = 1'b1;
			endcase
			nx_active = !stop;
			nx_done   = stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asz16_q <= 1'b0;
		end else if (cfg_wen) begin
			asz16_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			data_s1 <= s_axis_tdata[InUsedW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_off_q   <= '0;
			dst_off_q   <= '0;
			remaining_q <= '0;
			src_seg_q   <= '0;
			dst_seg_q   <= '0;
			mode_q      <= MODE_NONE;
			width_q     <= WIDTH_BYTE;
			dir_q       <= 1'b0;
			active_q    <= 1'b0;
			flags_q     <= '0;
		end else if (advance) begin
			src_off_q   <= nx_src_off;
			dst_off_q   <= nx_dst_off;
			remaining_q <= nx_remaining;
			src_seg_q   <= nx_src_seg;
			dst_seg_q   <= nx_dst_seg;
			mode_q      <= nx_mode;
			width_q     <= nx_width;
			dir_q       <= nx_dir;
			active_q    <= nx_active;
			flags_q     <= nx_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata[31:0]    <= nx_done ? 32'd0 : (nx_src_seg + nx_src_off);
			m_axis_tdata[63:32]   <= nx_done ? 32'd0 : (nx_dst_seg + nx_dst_off);
			m_axis_tdata[64]      <= nx_flags.cf;
			m_axis_tdata[65]      <= nx_flags.of;
			m_axis_tdata[66]      <= nx_flags.sf;
			m_axis_tdata[67]      <= nx_flags.zf;
			m_axis_tdata[68]      <= nx_flags.af;
			m_axis_tdata[100:69]  <= nx_src_off;
			m_axis_tdata[132:101] <= nx_dst_off;
			m_axis_tdata[164:133] <= nx_remaining;
			m_axis_tdata[167:165] <= 3'd0;
			m_axis_tuser          <= nx_done;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for the compare-string sequencer: drives start and element-pair
// requests with random idling at both ends and predicts each reply in a scoreboard class.
// Depends on scmp_pkg and string_compare_rep_sequencer.

module tb_top;
	import scmp_pkg::*;

	localparam int     RANDOM_ITEMS = 1900;
	localparam longint RUN_LIMIT    = 64'd5_000_000;
	localparam int     DRAIN_CYCLES = 4;

	// codes outside the defined set; the block treats them as no prefix / doubleword
	localparam logic [1:0] MODE_UNKNOWN = MODE_RSVD;
	localparam logic [1:0] WIDTH_ODD    = 2'd3;

	// request payload, last field first so source_offset lands in the low bits
	typedef struct packed {
		logic [31:0] dest_element;
		logic [31:0] source_element;
		logic [31:0] dest_base;
		logic [31:0] source_base;
		logic        direction;
		logic [1:0]  element_width;
		logic [1:0]  repeat_mode;
		logic [31:0] repeat_count;
		logic [31:0] dest_offset;
		logic [31:0] source_offset;
	} cmps_req_t;

	// reply payload with done on top (travels on tuser)
	typedef struct packed {
		logic        done;
		logic [31:0] count_left;
		logic [31:0] final_dest_offset;
		logic [31:0] final_source_offset;
		flags_t      flags;
		logic [31:0] dest_address;
		logic [31:0] source_address;
	} cmps_reply_t;

	class cmps_checker;
		logic        addr16;
		logic [31:0] si, di, cx, src_seg, dst_seg;
		logic [1:0]  mode_q, width_q;
		logic        df;
		flags_t      flags_q;
		logic        busy;
		cmps_reply_t replies_due[$];
		int          errors;

		function new();
			addr16 = 1'b0;
			si = '0; di = '0; cx = '0; src_seg = '0; dst_seg = '0;
			mode_q = MODE_NONE; width_q = WIDTH_BYTE; df = 1'b0;
			flags_q = '0; busy = 1'b0; errors = 0;
		endfunction

		function void set_addr16(logic v);
			addr16 = v;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function cmps_reply_t reply_now(logic fin);
			cmps_reply_t r;
			r.source_address      = fin ? 32'd0 : src_seg + si;
			r.dest_address        = fin ? 32'd0 : dst_seg + di;
			r.flags               = flags_q;
			r.final_source_offset = si;
			r.final_dest_offset   = di;
			r.count_left          = cx;
			r.done                = fin;
			return r;
		endfunction

		function void take_request(logic op, cmps_req_t q);
			logic [31:0] am, nb, emask, top, a, b, d, x;
			flags_t      f;
			logic        fin;
			am = addr16 ? 32'h0000_FFFF : 32'hFFFF_FFFF;
			if (op == OP_START) begin
				si = q.source_offset & am;
				di = q.dest_offset & am;
				mode_q = (q.repeat_mode == MODE_UNKNOWN) ? MODE_NONE : q.repeat_mode;
				width_q = q.element_width;
				df = q.direction;
				src_seg = q.source_base;
				dst_seg = q.dest_base;
				cx = (mode_q == MODE_NONE) ? 32'd1 : (q.repeat_count & am);
				busy = (cx != 32'd0);
				replies_due.push_back(reply_now(!busy));
			end else if (!busy) begin
				replies_due.push_back(reply_now(1'b1));
			end else begin
				case (width_q)
					WIDTH_BYTE: begin
						nb = 32'd1; emask = 32'h0000_00FF; top = 32'h0000_0080;
					end
					WIDTH_WORD: begin
						nb = 32'd2; emask = 32'h0000_FFFF; top = 32'h0000_8000;
					end
					default: begin
						nb = 32'd4; emask = 32'hFFFF_FFFF; top = 32'h8000_0000;
					end
				endcase
				a = q.source_element & emask;
				b = q.dest_element & emask;
				d = (a - b) & emask;
				x = a ^ b ^ d;
				f.cf = (a < b);
				f.of = |((a ^ b) & (a ^ d) & top);
				f.sf = |(d & top);
				f.zf = (d == 32'd0);
				f.af = x[4];
				flags_q = f;
				if (df) begin
					si = (si - nb) & am;
					di = (di - nb) & am;
				end else begin
					si = (si + nb) & am;
					di = (di + nb) & am;
				end
				cx = (cx - 32'd1) & am;
				fin = (cx == 32'd0) || (mode_q == MODE_NONE) ||
					(mode_q == MODE_REPE && !f.zf) || (mode_q == MODE_REPNE && f.zf);
				if (fin)
					busy = 1'b0;
				replies_due.push_back(reply_now(fin));
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on %s: expected %h, got %h", field, want, got);
			end
		endfunction

		function void check_reply(cmps_reply_t got);
			cmps_reply_t want;
			if (replies_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("reply with nothing outstanding: %h", got);
				return;
			end
			want = replies_due.pop_front();
			compare("source_address", want.source_address, got.source_address);
			compare("dest_address", want.dest_address, got.dest_address);
			compare("carry_flag", {31'b0, want.flags.cf}, {31'b0, got.flags.cf});
			compare("overflow_flag", {31'b0, want.flags.of}, {31'b0, got.flags.of});
			compare("sign_flag", {31'b0, want.flags.sf}, {31'b0, got.flags.sf});
			compare("zero_flag", {31'b0, want.flags.zf}, {31'b0, got.flags.zf});
			compare("adjust_flag", {31'b0, want.flags.af}, {31'b0, got.flags.af});
			compare("final_source_offset", want.final_source_offset, got.final_source_offset);
			compare("final_dest_offset", want.final_dest_offset, got.final_dest_offset);
			compare("count_left", want.count_left, got.count_left);
			compare("done_res", {31'b0, want.done}, {31'b0, got.done});
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wen;
	logic                cfg_wdata;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;   // source_offset, dest_offset, repeat_count, repeat_mode,
	                                     // element_width, direction, source_base, dest_base,
	                                     // source_element, dest_element
	logic                s_axis_tuser;   // opcode
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;   // source_address, dest_address, carry, overflow, sign,
	                                     // zero, adjust, final_source_offset, final_dest_offset,
	                                     // count_left
	logic                m_axis_tuser;   // done_res

	cmps_checker sb = new();
	int          items_sent;
	logic        send_fast;
	logic        sink_fast;

	string_compare_rep_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cmps_req_t make_start(logic [31:0] src, logic [31:0] dst,
		logic [31:0] cnt, logic [1:0] mode, logic [1:0] width, logic dir,
		logic [31:0] sbase, logic [31:0] dbase);
		cmps_req_t q;
		q.source_offset  = src;
		q.dest_offset    = dst;
		q.repeat_count   = cnt;
		q.repeat_mode    = mode;
		q.element_width  = width;
		q.direction      = dir;
		q.source_base    = sbase;
		q.dest_base      = dbase;
		q.source_element = $urandom;
		q.dest_element   = $urandom;
		return q;
	endfunction

	function automatic cmps_req_t make_pair(logic [31:0] a, logic [31:0] b);
		cmps_req_t q;
		q.source_offset  = $urandom;
		q.dest_offset    = $urandom;
		q.repeat_count   = $urandom;
		q.repeat_mode    = 2'($urandom_range(0, 3));
		q.element_width  = 2'($urandom_range(0, 3));
		q.direction      = 1'($urandom_range(0, 1));
		q.source_base    = $urandom;
		q.dest_base      = $urandom;
		q.source_element = a;
		q.dest_element   = b;
		return q;
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
			2:       return {16'($urandom), 16'hFFF0 | 16'($urandom_range(0, 15))};
			default: return 32'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return $urandom;
			2:       return 32'h0001_0000 * $urandom_range(1, 3) + 32'($urandom_range(0, 3));
			default: return 32'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic send_request(input logic op, input cmps_req_t q);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_fast = !send_fast;
		gap = send_fast ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(InDataW - InUsedW){1'b0}}, q};
		do @(posedge clk); while (!s_axis_tready);
		sb.take_request(op, q);
		items_sent++;
	endtask

	// hold the sender until every reply is back and the pipe has emptied
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_addr_size(input logic v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_addr16(v);
		cfg_wen <= 1'b0;
	endtask

	// one instruction: start request then pairs shaped to keep the repeat going
	task automatic run_random_string();
		cmps_req_t  q;
		logic [1:0] mode, width;
		logic [31:0] a, b;
		int          cap, n;
		case ($urandom_range(0, 15))
			0:       mode = MODE_UNKNOWN;
			1, 2, 3: mode = MODE_NONE;
			4, 5, 6, 7, 8, 9: mode = MODE_REPE;
			default: mode = MODE_REPNE;
		endcase
		case ($urandom_range(0, 12))
			0:          width = WIDTH_ODD;
			1, 2, 3, 4: width = WIDTH_BYTE;
			5, 6, 7, 8: width = WIDTH_WORD;
			default:    width = WIDTH_DWORD;
		endcase
		q = make_start(pick_offset(), pick_offset(), pick_count(), mode, width,
			1'($urandom_range(0, 1)), $urandom, $urandom);
		send_request(OP_START, q);
		cap = $urandom_range(1, 12);
		n = 0;
		while (sb.busy && n < cap) begin
			a = $urandom;
			case ($urandom_range(0, 7))
				0:       b = $urandom;
				1:       b = a ^ (32'd1 << $urandom_range(0, 31));
				default: b = (sb.mode_q == MODE_REPNE) ? a ^ (32'd1 << $urandom_range(0, 7)) : a;
			endcase
			send_request(OP_DATA, make_pair(a, b));
			n++;
		end
		// stray pair after the instruction has ended
		if ($urandom_range(0, 9) == 0)
			send_request(OP_DATA, make_pair($urandom, $urandom));
	endtask

	// reply side: random stalls, checked at each accepting edge
	initial begin
		int gap;
		sink_fast = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_fast = !sink_fast;
			gap = sink_fast ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_reply({m_axis_tuser, m_axis_tdata[OutDataW-4:0]});
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic cfg_val;
		int   next_switch;
		arst_n        <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_wdata     <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= OP_START;
		s_axis_tdata  <= '0;
		items_sent = 0;
		send_fast  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_addr_size(1'b0);
		// repeat with zero count finishes at once; pair while idle is ignored
		send_request(OP_START, make_start(32'h10, 32'h20, 32'd0, MODE_REPE, WIDTH_BYTE, 1'b0,
			32'h1000, 32'h2000));
		send_request(OP_START, make_start(32'h10, 32'h20, 32'd0, MODE_REPNE, WIDTH_WORD, 1'b0,
			32'h1000, 32'h2000));
		send_request(OP_DATA, make_pair(32'h0, 32'hFFFF_FFFF));
		// single byte compare with addresses wrapping past 2^32, borrow and adjust
		send_request(OP_START, make_start(32'hFFFF_FFFF, 32'h0, 32'h5, MODE_NONE, WIDTH_BYTE,
			1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_request(OP_DATA, make_pair(32'h0, 32'hFF));
		// REPE word, counting down through zero, an unequal pair with overflow ends it
		send_request(OP_START, make_start(32'h0, 32'h1, 32'd3, MODE_REPE, WIDTH_WORD, 1'b1,
			32'h0, 32'h8000_0000));
		send_request(OP_DATA, make_pair(32'hFFFF_FFFF, 32'h0000_FFFF));
		send_request(OP_DATA, make_pair(32'h8000, 32'h1));
		// REPNE dword until an equal pair
		send_request(OP_START, make_start(32'h100, 32'h200, 32'd5, MODE_REPNE, WIDTH_DWORD,
			1'b0, 32'h0, 32'h0));
		send_request(OP_DATA, make_pair(32'h0, 32'hFFFF_FFFF));
		send_request(OP_DATA, make_pair(32'h8000_0000, 32'h1));
		send_request(OP_DATA, make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// undefined mode and width codes
		send_request(OP_START, make_start(32'h40, 32'h80, 32'd9, MODE_UNKNOWN, WIDTH_ODD, 1'b1,
			32'h55, 32'hAA));
		send_request(OP_DATA, make_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF));
		// new start abandons a running instruction
		send_request(OP_START, make_start(32'h8, 32'h8, 32'd4, MODE_REPE, WIDTH_BYTE, 1'b0,
			32'h0, 32'h0));
		send_request(OP_DATA, make_pair(32'h1234_5611, 32'hABCD_EF11));
		send_request(OP_START, make_start(32'h30, 32'h34, 32'd2, MODE_REPE, WIDTH_BYTE, 1'b1,
			32'h0, 32'h0));
		send_request(OP_DATA, make_pair(32'h10, 32'h01));
		wait_idle();

		// 16-bit addressing: count truncates to zero, offsets wrap at 64K
		write_addr_size(1'b1);
		send_request(OP_START, make_start(32'h1234_0010, 32'h0, 32'h0001_0000, MODE_REPE,
			WIDTH_BYTE, 1'b0, 32'h0, 32'h0));
		send_request(OP_START, make_start(32'hFFFF_FFFF, 32'hABCD_FFFE, 32'h0001_0002,
			MODE_REPE, WIDTH_BYTE, 1'b0, 32'hFFFF_0000, 32'h10));
		send_request(OP_DATA, make_pair(32'h77, 32'h77));
		send_request(OP_DATA, make_pair(32'h77, 32'h77));
		send_request(OP_START, make_start(32'h0000_0001, 32'h0, 32'd3, MODE_REPNE, WIDTH_DWORD,
			1'b1, 32'h0, 32'h0));
		send_request(OP_DATA, make_pair(32'h1, 32'h2));
		wait_idle();

		cfg_val = 1'b0;
		write_addr_size(cfg_val);
		next_switch = items_sent + $urandom_range(100, 250);
		while (items_sent < 25 + RANDOM_ITEMS) begin
			run_random_string();
			if (items_sent >= next_switch) begin
				wait_idle();
				cfg_val = !cfg_val;
				write_addr_size(cfg_val);
				next_switch = items_sent + $urandom_range(100, 250);
			end else if ($urandom_range(0, 60) == 0) begin
				wait_idle();
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: string_compare_rep_sequencer.f
rtl/scmp_pkg.sv
rtl/scmp_alu.sv
rtl/string_compare_rep_sequencer.sv
tb/sv/tb_top.sv
